FILE: rtl/core/dq_pkg.sv
// Shared types and constants for the deque block: command codes, jump
// conditions, control word layout and the sequencer microprogram.
// No dependencies.
package dq_pkg;

    // Default number of entries in the ring store
    localparam int DQ_DEPTH = 16;

    // Step counter width and microprogram step addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_EXEC  = 3'd1;
    localparam step_t STEP_CHECK = 3'd2;
    localparam step_t STEP_DUMP  = 3'd3;
    localparam step_t STEP_EMPTY = 3'd4;

    // Command codes of the input item
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_PUSH    = 2'd1,
        CMD_POP     = 2'd2
    } cmd_t;

    // Jump conditions evaluated by the sequencer
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_START,
        COND_EMPTY,
        COND_LAST,
        COND_ALWAYS
    } cond_t;

    // One control word: datapath strobes plus branch control.
    // Next step = cond ? target : (hold ? this step : this step + 1)
    typedef struct packed {
        logic  busy;
        logic  exec;
        logic  rd;
        logic  emit_empty;
        cond_t cond;
        logic  hold;
        step_t target;
    } ucode_t;

    // Microprogram ROM
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{busy: 1'b0, exec: 1'b0, rd: 1'b0, emit_empty: 1'b0,
              cond: COND_NEVER, hold: 1'b0, target: STEP_IDLE};
        case (step)
            // wait for a command
            STEP_IDLE: begin
                w.cond   = COND_NO_START;
                w.target = STEP_IDLE;
            end
            // apply the command to pointers and store
            STEP_EXEC: begin
                w.busy = 1'b1;
                w.exec = 1'b1;
            end
            // empty queue takes the single-result path
            STEP_CHECK: begin
                w.busy   = 1'b1;
                w.cond   = COND_EMPTY;
                w.target = STEP_EMPTY;
            end
            // read one entry per cycle until the back is reached
            STEP_DUMP: begin
                w.busy   = 1'b1;
                w.rd     = 1'b1;
                w.cond   = COND_LAST;
                w.target = STEP_IDLE;
                w.hold   = 1'b1;
            end
            STEP_EMPTY: begin
                w.busy       = 1'b1;
                w.emit_empty = 1'b1;
                w.cond       = COND_ALWAYS;
                w.target     = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/deque_push_pop_with_dump.sv
// Top level of the bounded deque with contents dump after every command.
// Depends on dq_pkg (command codes, control word type, microprogram ROM).
//
// Usage:
//   Input channel: drive command and value with start high; the item is
//   taken at a rising edge where start is high and busy is low. command is
//   enqueue at back, push at front or pop from front; code 3 does nothing.
//   Output channel: strobe marks each result for exactly one cycle. After a
//   command the whole contents come out front to back, one per cycle, with
//   is_last on the final one; an empty queue gives one result with
//   is_empty and is_last set and element zero. dropped_full is set on every
//   result of an insert that found the store full.
//   Sequence: after the accept edge busy stays high through execute, empty
//   check and N reads when N entries remain, or through execute, empty
//   check and empty result for an empty queue. The first result is
//   registered from the first read, and the last one is on the ports in the
//   cycle busy is low again, so a new command can be taken then; no command
//   is taken while a dump is still running. The dump rate is set by the
//   single read port of the ring store, one entry per cycle.
//   Reset: pointers and count clear, queue is empty; store contents are not
//   cleared. The receiver cannot stall the results.
module deque_push_pop_with_dump #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    output logic               strobe,
    output logic signed [31:0] element,
    output logic               is_empty,
    output logic               is_last,
    output logic               dropped_full
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // ring store
    logic signed [31:0] mem [DEPTH];

    // sequencer state
    step_t  pc_reg, pc_next;
    ucode_t uw;
    logic   cond_hit;

    // datapath registers
    logic [1:0]         cmd_reg;
    logic signed [31:0] val_reg;
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               drop_reg, drop_next;

    // output registers
    logic               strobe_reg;
    logic signed [31:0] rd_data_reg;
    logic               empty_reg;
    logic               last_reg;
    logic               drop_out_reg;

    // datapath helpers
    logic          accept;
    logic          is_last_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] back_slot;

    // modular add of two slot offsets, both below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // control word fetch
    assign uw     = ucode_rom(pc_reg);
    assign busy   = uw.busy;
    assign accept = start && !uw.busy;

    assign is_last_idx = (CW'(idx_reg) == (count_reg - CW'(1)));

    // branch condition select
    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_NO_START: cond_hit = !start;
            COND_EMPTY:    cond_hit = (count_reg == '0);
            COND_LAST:     cond_hit = is_last_idx;
            COND_ALWAYS:   cond_hit = 1'b1;
            default:       cond_hit = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        if (cond_hit) begin
            pc_next = uw.target;
        end else if (uw.hold) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    // pointer arithmetic
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);
    assign back_slot = wrap_add(front_reg, count_reg[AW-1:0]);
    assign rd_addr   = wrap_add(front_reg, idx_reg);

    // command execution
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = back_slot;
        if (uw.exec) begin
            drop_next = 1'b0;
            idx_next  = '0;
            case (cmd_reg)
                CMD_ENQUEUE: begin
                    if (count_reg == FULL_CNT) begin
                        drop_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = back_slot;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH: begin
                    if (count_reg == FULL_CNT) begin
                        drop_next = 1'b1;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP: begin
                    if (count_reg != '0) begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (uw.rd) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg       <= STEP_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            drop_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            empty_reg    <= 1'b0;
            last_reg     <= 1'b0;
            drop_out_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            drop_reg     <= drop_next;
            strobe_reg   <= uw.rd || uw.emit_empty;
            empty_reg    <= uw.emit_empty;
            last_reg     <= uw.emit_empty || (uw.rd && is_last_idx);
            drop_out_reg <= drop_reg;
        end
    end

    // command latch
    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg <= command;
            val_reg <= value;
        end
    end

    // ring store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= val_reg;
        end
        if (uw.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result ports
    assign strobe       = strobe_reg;
    assign element      = empty_reg ? 32'sd0 : rd_data_reg;
    assign is_empty     = empty_reg;
    assign is_last      = last_reg;
    assign dropped_full = drop_out_reg;

endmodule

FILE: tb/deque_push_pop_with_dump_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded deque with a contents dump after every command.
// Depends on dq_pkg (command codes, default depth) and on deque_push_pop_with_dump.
module deque_push_pop_with_dump_tb;

    import dq_pkg::*;

    // Unused command code: no change, contents still dumped
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;

    // One command waiting to be driven
    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] val;
        int unsigned        gap_after;
        bit                 drain_first;
    } stim_item_t;

    // One dumped entry as the block should emit it
    typedef struct {
        logic signed [31:0] element;
        logic               is_empty;
        logic               is_last;
        logic               dropped_full;
    } dump_entry_t;

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         command = '0;
    logic signed [31:0] value = '0;
    logic               strobe;
    logic signed [31:0] element;
    logic               is_empty;
    logic               is_last;
    logic               dropped_full;

    // Deque shadow state
    logic signed [31:0] ring_shadow [DQ_DEPTH];
    int                 head_idx = 0;
    int                 live_count = 0;

    stim_item_t  pend_q[$];
    dump_entry_t dump_q[$];
    int          n_sent = 0;
    int          n_taken = 0;
    int          n_items = 0;
    int unsigned gap_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    deque_push_pop_with_dump #(
        .DEPTH(DQ_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .value       (value),
        .strobe      (strobe),
        .element     (element),
        .is_empty    (is_empty),
        .is_last     (is_last),
        .dropped_full(dropped_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Apply one command to the shadow deque and queue up its dump
    task automatic apply_command(input logic [1:0] cmd, input logic signed [31:0] val);
        logic        dropped;
        dump_entry_t ent;
        int          k;
        dropped = 1'b0;
        case (cmd)
            CMD_ENQUEUE, CMD_PUSH:
            begin
                if (live_count >= DQ_DEPTH)
                    dropped = 1'b1;
                else if (cmd == CMD_ENQUEUE)
                begin
                    ring_shadow[(head_idx + live_count) % DQ_DEPTH] = val;
                    live_count++;
                end
                else
                begin
                    head_idx = (head_idx + DQ_DEPTH - 1) % DQ_DEPTH;
                    ring_shadow[head_idx] = val;
                    live_count++;
                end
            end
            CMD_POP:
            begin
                if (live_count != 0)
                begin
                    head_idx = (head_idx + 1) % DQ_DEPTH;
                    live_count--;
                end
            end
            default: ;
        endcase
        // empty queue: a single flagged result
        if (live_count == 0)
        begin
            ent = '{32'sd0, 1'b1, 1'b1, dropped};
            dump_q.push_back(ent);
        end
        else
        begin
            for (k = 0; k < live_count; k++)
            begin
                ent.element      = ring_shadow[(head_idx + k) % DQ_DEPTH];
                ent.is_empty     = 1'b0;
                ent.is_last      = (k == live_count - 1);
                ent.dropped_full = dropped;
                dump_q.push_back(ent);
            end
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic add_item(input logic [1:0] cmd, input logic signed [31:0] val,
                            input int unsigned gap, input bit drain);
        stim_item_t it;
        it.cmd         = cmd;
        it.val         = val;
        it.gap_after   = gap;
        it.drain_first = drain;
        pend_q.push_back(it);
    endtask

    // Driver: changes inputs on the falling edge
    always @(negedge clk)
    begin : driver
        stim_item_t nxt;
        bit         launch;
        launch = 1'b0;
        if (rst_n && !(start && n_taken < n_sent))
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pend_q.size() != 0 && (!pend_q[0].drain_first || dump_q.size() == 0))
                launch = 1'b1;
            if (launch)
            begin
                nxt = pend_q.pop_front();
                start    <= 1'b1;
                command  <= nxt.cmd;
                value    <= nxt.val;
                gap_left <= nxt.gap_after;
                n_sent   <= n_sent + 1;
            end
            else
            begin
                // idle: junk on the payload
                start   <= 1'b0;
                command <= 2'($urandom);
                value   <= $urandom;
            end
        end
    end

    // Monitor: checks results and records accepted items on the rising edge
    always @(posedge clk)
    begin : monitor
        dump_entry_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (dump_q.size() == 0)
                    report_mismatch($sformatf("unexpected result element=%0d", element));
                else
                begin
                    want = dump_q.pop_front();
                    if (element !== want.element)
                        report_mismatch($sformatf("element %0d, want %0d",
                                                  element, want.element));
                    if (is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, want %b",
                                                  is_empty, want.is_empty));
                    if (is_last !== want.is_last)
                        report_mismatch($sformatf("is_last %b, want %b",
                                                  is_last, want.is_last));
                    if (dropped_full !== want.dropped_full)
                        report_mismatch($sformatf("dropped_full %b, want %b",
                                                  dropped_full, want.dropped_full));
                end
            end
            // new dump goes behind any still pending
            if (start && !busy)
            begin
                apply_command(command, value);
                n_taken <= n_taken + 1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          p;
        int          k;
        int          mode;
        int          len;
        int unsigned r;
        bit          no_idle;
        logic [1:0]  c;

        // Directed: empty cases, extremes, fill to full, inserts into a full store
        add_item(CMD_POP, 32'sd5, 0, 1'b0);
        add_item(CMD_NOP, 32'sd0, 1, 1'b0);
        add_item(CMD_ENQUEUE, 32'sh7FFF_FFFF, 0, 1'b0);
        add_item(CMD_PUSH, 32'sh8000_0000, 0, 1'b0);
        add_item(CMD_ENQUEUE, -32'sd1, 2, 1'b0);
        add_item(CMD_PUSH, 32'sd0, 0, 1'b0);
        add_item(CMD_NOP, 32'sh5555_AAAA, 0, 1'b0);
        for (k = 0; k < DQ_DEPTH - 4; k++)
            add_item((k % 2) ? CMD_PUSH : CMD_ENQUEUE, $urandom, k % 3, 1'b0);
        add_item(CMD_ENQUEUE, 32'sh1234_5678, 0, 1'b1);
        add_item(CMD_PUSH, -32'sd2, 0, 1'b0);
        add_item(CMD_POP, 32'sd0, 0, 1'b0);
        add_item(CMD_PUSH, 32'shAAAA_5555, 0, 1'b0);

        // Random phases: filling, draining and mixed traffic
        p = 0;
        while (p < 430)
        begin
            mode    = $urandom_range(0, 2);
            len     = $urandom_range(8, 40);
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: c = (r < 45) ? CMD_ENQUEUE : (r < 85) ? CMD_PUSH :
                           (r < 97) ? CMD_POP : CMD_NOP;
                    1: c = (r < 10) ? CMD_ENQUEUE : (r < 20) ? CMD_PUSH :
                           (r < 97) ? CMD_POP : CMD_NOP;
                    default: c = (r < 30) ? CMD_ENQUEUE : (r < 60) ? CMD_PUSH :
                                 (r < 95) ? CMD_POP : CMD_NOP;
                endcase
                add_item(c, pick_value(), no_idle ? 0 : pick_gap(),
                         ($urandom_range(0, 24) == 0));
            end
            p += len;
        end
        n_items = pend_q.size();

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_taken < n_items)
            @(posedge clk);
        while (dump_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: deque_push_pop_with_dump.f
rtl/core/dq_pkg.sv
rtl/core/deque_push_pop_with_dump.sv
tb/deque_push_pop_with_dump_tb.sv
